// ===== rtl/hctb_pkg.sv =====
// ----------------------------------------------------------------------------
// hctb_pkg
// Shared constants and types for the Huffman code tree builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hctb_pkg;

    // Default sizing of the block.
    localparam int MAX_WORDS_DEF  = 1024;
    localparam int MAX_CODE_DEF   = 40;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths of the channels.
    localparam int COUNT_IN_W = 32;
    localparam int INDEX_W    = 10;
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 6;
    localparam int ERR_W      = 2;

    // Width of a node weight; sums saturate at the top of this range.
    localparam int WEIGHT_W = 48;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_WORD  = 2'd1,
        ERR_TOO_LONG = 2'd2
    } err_t;

endpackage

`default_nettype wire

// ===== rtl/hctb_if.sv =====
// ----------------------------------------------------------------------------
// hctb_if
// Valid/ready channel interfaces for the item and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

interface hctb_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [hctb_pkg::COUNT_IN_W-1:0]   word_count;
    logic                              final_req;
    logic [hctb_pkg::INDEX_W-1:0]      word_index;

    modport source (output valid, output kind, output word_count, output final_req,
                    output word_index, input ready);
    modport sink   (input valid, input kind, input word_count, input final_req,
                    input word_index, output ready);
endinterface

interface hctb_out_if;
    logic                              valid;
    logic                              ready;
    logic                              code_bit;
    logic [hctb_pkg::NODE_W-1:0]       node_index;
    logic [hctb_pkg::DEPTH_W-1:0]      depth;
    logic                              last;
    logic [hctb_pkg::ERR_W-1:0]        error;

    modport source (output valid, output code_bit, output node_index, output depth,
                    output last, output error, input ready);
    modport sink   (input valid, input code_bit, input node_index, input depth,
                    input last, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/huffman_code_tree_builder_top.sv =====
// ----------------------------------------------------------------------------
// huffman_code_tree_builder_top
// Builds a Huffman tree from sorted word counts and answers code queries.
// ----------------------------------------------------------------------------
// Usage. Beats arrive on the item channel. A load beat (kind 0) stores one word
// count; counts are expected in descending order. A load beat with final_req set
// closes the set and starts the tree build. The first load after a build opens
// a new set. Loads past MAX_WORDS are dropped, but a final marker still builds.
// A query beat (kind 1) asks for the code of word_index; the block answers on
// the result channel with one beat per tree level, root first, with last set on
// the final beat. A bad query or a code longer than MAX_CODE gives one beat with
// an error code and last set.
// Flow. A plain load leaves the block idle. A final load of two or more words
// keeps item.ready low while the shared compare/add unit merges two queue heads
// per node, S_B_PICK1 then S_B_PICK2 (one weight memory read port per queue).
// A query walks the parent links, S_Q_TEST then S_Q_STEP per level, then puts
// out its result beats from the path buffer, S_E_RD then S_E_OUT per beat;
// item.ready returns when the last beat is in the output register.
// Reset clears the word count and the tree-ready flag; the memories are not
// cleared, since a build writes every entry that a later query reads.
// When the receiver stalls, the output register holds its beat and the emit
// steps wait; a load can still be taken while the final result beat waits.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_tree_builder_top #(
    parameter int MAX_WORDS  = hctb_pkg::MAX_WORDS_DEF,
    parameter int MAX_CODE   = hctb_pkg::MAX_CODE_DEF,
    parameter int COUNT_BITS = hctb_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hctb_in_if.sink     item,
    hctb_out_if.source  result
);
    import hctb_pkg::*;

    localparam int SLOTS  = 2 * MAX_WORDS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int LEN_W  = $clog2(MAX_CODE + 1);
    localparam int PIDX_W = $clog2(MAX_CODE);
    localparam int KEEP_W = (COUNT_BITS < COUNT_IN_W) ? COUNT_BITS : COUNT_IN_W;
    localparam int CMP_W  = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_B_FETCH = 9'b000000010,
        S_B_PICK1 = 9'b000000100,
        S_B_PICK2 = 9'b000001000,
        S_Q_TEST  = 9'b000010000,
        S_Q_STEP  = 9'b000100000,
        S_Q_ERR   = 9'b001000000,
        S_E_RD    = 9'b010000000,
        S_E_OUT   = 9'b100000000
    } state_t;

    // Control registers.
    state_t             state_reg,       state_next;
    logic [CNT_W-1:0]   n_reg,           n_next;
    logic               tree_ready_reg,  tree_ready_next;
    logic [SLOT_W-1:0]  leaf_left_reg,   leaf_left_next;
    logic [SLOT_W-1:0]  inner_pos_reg,   inner_pos_next;
    logic [SLOT_W-1:0]  made_reg,        made_next;
    logic               byp_reg,         byp_next;
    logic [SLOT_W-1:0]  cur_reg,         cur_next;
    logic [LEN_W-1:0]   len_reg,         len_next;
    logic [PIDX_W-1:0]  d_reg,           d_next;
    err_t               err_reg,         err_next;
    logic               out_valid_reg,   out_valid_next;

    // Datapath registers.
    logic [WEIGHT_W-1:0] w1_reg,  w1_next;
    logic [WEIGHT_W-1:0] sum_reg, sum_next;
    logic                code_bit_reg, code_bit_next;
    logic [NODE_W-1:0]   node_reg,     node_next;
    logic [DEPTH_W-1:0]  depth_reg,    depth_next;
    logic                last_reg,     last_next;
    logic [ERR_W-1:0]    error_reg,    error_next;

    // Memories: node weights, parent links with branch bit, and the path buffer.
    logic [WEIGHT_W-1:0] weight_mem [SLOTS];
    logic [SLOT_W:0]     link_mem   [SLOTS];
    logic [SLOT_W:0]     path_mem   [MAX_CODE];

    logic [WEIGHT_W-1:0] leaf_q, inner_q;
    logic [SLOT_W:0]     link_q, path_q;

    logic                wt_we;
    logic [SLOT_W-1:0]   wt_waddr;
    logic [WEIGHT_W-1:0] wt_wdata;
    logic                link_we;
    logic [SLOT_W-1:0]   link_waddr;
    logic [SLOT_W:0]     link_wdata;
    logic                path_we;
    logic [SLOT_W-1:0]   leaf_raddr, inner_raddr;
    logic [LEN_W-1:0]    path_rpos;

    logic                accept, out_free;
    logic [CNT_W:0]      n_dbl;
    logic [SLOT_W-1:0]   root;
    logic [CNT_W-1:0]    n_base, n_after;
    logic                has_room;
    logic [WEIGHT_W-1:0] load_w;

    logic                leaf_ok, inner_ok, take_leaf;
    logic [WEIGHT_W-1:0] inner_w, pick_w, sum_sat;
    logic [SLOT_W-1:0]   pick_slot;
    logic [WEIGHT_W:0]   sum_full;
    logic [SLOT_W-1:0]   node_diff;
    logic                at_last;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.code_bit   = code_bit_reg;
    assign result.node_index = node_reg;
    assign result.depth      = depth_reg;
    assign result.last       = last_reg;
    assign result.error      = error_reg;

    // Root slot of the current set is 2n-2.
    assign n_dbl = {n_reg, 1'b0};
    assign root  = SLOT_W'(n_dbl - (CNT_W + 1)'(2));

    // Load bookkeeping: a load after a build restarts the set.
    assign n_base   = tree_ready_reg ? '0 : n_reg;
    assign has_room = (n_base < CNT_W'(MAX_WORDS));
    assign n_after  = has_room ? (n_base + CNT_W'(1)) : n_base;
    assign load_w   = WEIGHT_W'(item.word_count[KEEP_W-1:0]);

    // Shared pick unit: the smaller queue head, the inner node winning ties.
    assign leaf_ok   = (leaf_left_reg != '0);
    assign inner_ok  = (inner_pos_reg < made_reg);
    assign inner_w   = byp_reg ? sum_reg : inner_q;
    assign take_leaf = leaf_ok && (!inner_ok || (leaf_q < inner_w));
    assign pick_slot = take_leaf ? (leaf_left_reg - SLOT_W'(1)) : inner_pos_reg;
    assign pick_w    = take_leaf ? leaf_q : inner_w;
    assign sum_full  = {1'b0, w1_reg} + {1'b0, pick_w};
    assign sum_sat   = sum_full[WEIGHT_W] ? '1 : sum_full[WEIGHT_W-1:0];

    // Emit side: the path buffer is read from the root end downward.
    assign path_rpos = len_reg - LEN_W'(1) - LEN_W'(d_reg);
    assign node_diff = path_q[SLOT_W-1:0] - SLOT_W'(n_reg);
    assign at_last   = ((LEN_W'(d_reg) + LEN_W'(1)) == len_reg);

    // Memory read addresses follow the next pointer values, so the read data
    // matches the registered pointers in the following cycle.
    assign leaf_raddr  = leaf_left_next - SLOT_W'(1);
    assign inner_raddr = inner_pos_next;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        tree_ready_next = tree_ready_reg;
        leaf_left_next  = leaf_left_reg;
        inner_pos_next  = inner_pos_reg;
        made_next       = made_reg;
        byp_next        = byp_reg;
        cur_next        = cur_reg;
        len_next        = len_reg;
        d_next          = d_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        w1_next         = w1_reg;
        sum_next        = sum_reg;
        code_bit_next   = code_bit_reg;
        node_next       = node_reg;
        depth_next      = depth_reg;
        last_next       = last_reg;
        error_next      = error_reg;
        wt_we           = 1'b0;
        wt_waddr        = SLOT_W'(n_base);
        wt_wdata        = load_w;
        link_we         = 1'b0;
        link_waddr      = pick_slot;
        link_wdata      = {1'b0, made_reg};
        path_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.kind == KIND_LOAD))
                begin
                    wt_we           = has_room;
                    n_next          = n_after;
                    tree_ready_next = item.final_req;
                    if (item.final_req && (n_after >= CNT_W'(2)))
                    begin
                        leaf_left_next = SLOT_W'(n_after);
                        inner_pos_next = SLOT_W'(n_after);
                        made_next      = SLOT_W'(n_after);
                        byp_next       = 1'b0;
                        state_next     = S_B_FETCH;
                    end
                end
                else if (accept)
                begin
                    len_next = '0;
                    cur_next = SLOT_W'(item.word_index);
                    if (!tree_ready_reg || (n_reg < CNT_W'(2)) ||
                        (CMP_W'(item.word_index) >= CMP_W'(n_reg)))
                    begin
                        err_next   = ERR_NO_WORD;
                        state_next = S_Q_ERR;
                    end
                    else
                    begin
                        state_next = S_Q_TEST;
                    end
                end
            end

            S_B_FETCH:
            begin
                state_next = S_B_PICK1;
            end

            S_B_PICK1:
            begin
                w1_next    = pick_w;
                link_we    = 1'b1;
                link_wdata = {1'b0, made_reg};
                if (take_leaf)
                begin
                    leaf_left_next = leaf_left_reg - SLOT_W'(1);
                end
                else
                begin
                    inner_pos_next = inner_pos_reg + SLOT_W'(1);
                end
                byp_next   = 1'b0;
                state_next = S_B_PICK2;
            end

            S_B_PICK2:
            begin
                link_we    = 1'b1;
                link_wdata = {1'b1, made_reg};
                wt_we      = 1'b1;
                wt_waddr   = made_reg;
                wt_wdata   = sum_sat;
                sum_next   = sum_sat;
                if (take_leaf)
                begin
                    leaf_left_next = leaf_left_reg - SLOT_W'(1);
                end
                else
                begin
                    inner_pos_next = inner_pos_reg + SLOT_W'(1);
                end
                // The inner head may be the node written at this very edge.
                byp_next = (inner_pos_next == made_reg);
                if (made_reg == root)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    made_next  = made_reg + SLOT_W'(1);
                    state_next = S_B_PICK1;
                end
            end

            S_Q_TEST:
            begin
                if (cur_reg == root)
                begin
                    d_next     = '0;
                    state_next = S_E_RD;
                end
                else if (len_reg == LEN_W'(MAX_CODE))
                begin
                    err_next   = ERR_TOO_LONG;
                    state_next = S_Q_ERR;
                end
                else
                begin
                    state_next = S_Q_STEP;
                end
            end

            S_Q_STEP:
            begin
                path_we    = 1'b1;
                cur_next   = link_q[SLOT_W-1:0];
                len_next   = len_reg + LEN_W'(1);
                state_next = S_Q_TEST;
            end

            S_Q_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_bit_next  = 1'b0;
                    node_next      = '0;
                    depth_next     = '0;
                    last_next      = 1'b1;
                    error_next     = err_reg;
                    state_next     = S_IDLE;
                end
            end

            S_E_RD:
            begin
                state_next = S_E_OUT;
            end

            S_E_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_bit_next  = path_q[SLOT_W];
                    node_next      = NODE_W'(node_diff);
                    depth_next     = DEPTH_W'(d_reg);
                    last_next      = at_last;
                    error_next     = ERR_OK;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + PIDX_W'(1);
                        state_next = S_E_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            n_reg          <= '0;
            tree_ready_reg <= 1'b0;
            leaf_left_reg  <= '0;
            inner_pos_reg  <= '0;
            made_reg       <= '0;
            byp_reg        <= 1'b0;
            cur_reg        <= '0;
            len_reg        <= '0;
            d_reg          <= '0;
            err_reg        <= ERR_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            tree_ready_reg <= tree_ready_next;
            leaf_left_reg  <= leaf_left_next;
            inner_pos_reg  <= inner_pos_next;
            made_reg       <= made_next;
            byp_reg        <= byp_next;
            cur_reg        <= cur_next;
            len_reg        <= len_next;
            d_reg          <= d_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg       <= w1_next;
        sum_reg      <= sum_next;
        code_bit_reg <= code_bit_next;
        node_reg     <= node_next;
        depth_reg    <= depth_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

    // Weight memory: one write port, two registered read ports (queue heads).
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            weight_mem[wt_waddr] <= wt_wdata;
        end
        leaf_q  <= weight_mem[leaf_raddr];
        inner_q <= weight_mem[inner_raddr];
    end

    // Parent link memory with the branch bit of each node below its parent.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[cur_reg];
    end

    // Path buffer: entry j holds the branch bit of the node j steps above the leaf
    // on the walk and its parent slot.
    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[len_reg[PIDX_W-1:0]] <= link_q;
        end
        path_q <= path_mem[path_rpos[PIDX_W-1:0]];
    end

endmodule

`default_nettype wire

// ===== rtl/hctb_checker.sv =====
// ----------------------------------------------------------------------------
// hctb_checker
// Port-level assertions for the Huffman code tree builder, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module hctb_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          in_kind,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          code_bit,
    input  wire logic [hctb_pkg::NODE_W-1:0]   node_index,
    input  wire logic [hctb_pkg::DEPTH_W-1:0]  depth,
    input  wire logic                          last,
    input  wire logic [hctb_pkg::ERR_W-1:0]    error
);
    import hctb_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable({code_bit, node_index, depth, last, error}))
        else $error("result beat changed while stalled");

    // A query occupies the block, so no item can follow in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == KIND_QUERY) |=> !in_ready)
        else $error("item accepted right after a query");

    // While a code is only partly delivered, the block takes no new item.
    a_mid_code_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("item channel ready in the middle of a code");

    // Error beats are single, zeroed and carry a defined code.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != ERR_OK) |->
            last && !code_bit && (node_index == '0) && (depth == '0) &&
            ((error == ERR_NO_WORD) || (error == ERR_TOO_LONG)))
        else $error("malformed error beat");

endmodule

bind huffman_code_tree_builder_top hctb_checker u_hctb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_kind    (item.kind),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .code_bit   (result.code_bit),
    .node_index (result.node_index),
    .depth      (result.depth),
    .last       (result.last),
    .error      (result.error)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for huffman_code_tree_builder_top. Word count sets are
// loaded over the item channel and the builder is then asked for code paths.
// A behavioral copy of the two-queue Huffman merge runs alongside the block
// and predicts every untyped result beat. The run has three parts: a table of
// directed beats, a set that overruns the word capacity, and a long stretch of
// random sets and queries. Both channels idle at random, and once the result
// side holds off long enough to back the block up onto its item channel.
// ----------------------------------------------------------------------------

module testbench;

    import hctb_pkg::*;

    localparam int MAX_WORDS        = MAX_WORDS_DEF;
    localparam int MAX_CODE         = MAX_CODE_DEF;
    localparam int COUNT_BITS       = COUNT_BITS_DEF;
    localparam int SLOTS            = 2 * MAX_WORDS;
    localparam int RANDOM_ITEMS     = 290;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 300;
    localparam int N_DIRECTED       = 28;

    // One result beat as the block should put it out.
    typedef struct packed {
        logic               code_bit;
        logic [NODE_W-1:0]  node_index;
        logic [DEPTH_W-1:0] depth;
        logic               last;
        err_t               error;
    } code_beat_t;

    // One row of the directed table. A load row with reps above one is
    // repeated with the same count, and only its last beat carries final_req.
    // Rows with typed set carry their single answer beat directly.
    typedef struct {
        logic                  kind;
        logic [COUNT_IN_W-1:0] count;
        logic                  final_req;
        logic [INDEX_W-1:0]    index;
        int                    reps;
        bit                    typed;
        logic                  t_bit;
        logic [NODE_W-1:0]     t_node;
        err_t                  t_err;
    } stim_row_t;

    logic clk;
    logic rst_n;

    hctb_in_if  item_ch ();
    hctb_out_if result_ch ();

    huffman_code_tree_builder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the tree builder. Inner node k of an n-word set lives in
    // slot n+k, so the root sits in slot 2n-2.
    // ------------------------------------------------------------------------
    logic [WEIGHT_W-1:0] tree_weight [SLOTS];
    logic [10:0]         tree_parent [SLOTS];
    bit                  tree_branch [SLOTS];
    int                  set_size   = 0;
    bit                  tree_built = 1'b0;

    // Beats that the block still owes us, oldest first.
    code_beat_t code_beats_due [$];

    int  mismatches     = 0;
    int  items_accepted = 0;
    bit  random_phase   = 1'b0;
    bit  long_hold      = 1'b0;
    int  burst_left [2] = '{0, 0};
    code_beat_t no_beat = '0;

    // Directed beats. Answers are typed in only where they are obvious: queries
    // without a tree or past the set, the two-word set, and codes past the limit.
    stim_row_t directed_rows [N_DIRECTED] = '{
        // Query straight after reset: there is no tree yet.
        '{KIND_QUERY, 32'd0,          1'b0, 10'd0,    1,  1'b1, 1'b0, 10'd0, ERR_NO_WORD},
        // A loaded word without a final marker still gives no tree.
        '{KIND_LOAD,  32'hFFFF_FFFF,  1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd0,    1,  1'b1, 1'b0, 10'd0, ERR_NO_WORD},
        // Largest and smallest count make the two-word tree: the small leaf is
        // taken first and gets bit 0, the large one gets bit 1.
        '{KIND_LOAD,  32'd0,          1'b1, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd0,    1,  1'b1, 1'b1, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'hFFFF_FFFF,  1'b1, 10'd1,    1,  1'b1, 1'b0, 10'd0, ERR_OK},
        // Word indexes past the set, the highest index among them.
        '{KIND_QUERY, 32'd0,          1'b0, 10'd2,    1,  1'b1, 1'b0, 10'd0, ERR_NO_WORD},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd1023, 1,  1'b1, 1'b0, 10'd0, ERR_NO_WORD},
        // A load after a build opens a new set; one word builds nothing.
        '{KIND_LOAD,  32'd5,          1'b1, 10'd1023, 1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd0,    1,  1'b1, 1'b0, 10'd0, ERR_NO_WORD},
        // All-zero counts: ties go to the inner node, so the tree degenerates
        // into a chain. 41 words put the two deepest leaves exactly at the limit.
        '{KIND_LOAD,  32'd0,          1'b1, 10'd0,    41, 1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd40,   1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        // One word more pushes them one level past the limit.
        '{KIND_LOAD,  32'd0,          1'b1, 10'd0,    42, 1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd41,   1,  1'b1, 1'b0, 10'd0, ERR_TOO_LONG},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd40,   1,  1'b1, 1'b0, 10'd0, ERR_TOO_LONG},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd1,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        // A sorted set with a tie between two leaves.
        '{KIND_LOAD,  32'd100,        1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_LOAD,  32'd60,         1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_LOAD,  32'd30,         1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_LOAD,  32'd30,         1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_LOAD,  32'd10,         1'b1, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd3,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd4,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        // Counts in the wrong order still run through the same merge.
        '{KIND_LOAD,  32'd1,          1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_LOAD,  32'd50,         1'b1, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd0,    1,  1'b0, 1'b0, 10'd0, ERR_OK},
        '{KIND_QUERY, 32'd0,          1'b0, 10'd1,    1,  1'b0, 1'b0, 10'd0, ERR_OK}
    };

    // Wait before the next beat on one side (0 = items, 1 = results). Now and
    // then a burst of back-to-back beats is drawn instead of single gaps.
    function automatic int draw_wait(int side);
        if (burst_left[side] > 0)
        begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left[side] = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // A load stores one count; a final load runs the two-queue merge. Leaves
    // leave from the tail of the count list, inner nodes from the front of the
    // inner queue, and a leaf is taken only when it is strictly lighter. An
    // inner slot not yet made counts as heavier than anything.
    function automatic void load_word_count(logic [COUNT_IN_W-1:0] cnt, logic fin);
        int                n;
        int                leaf_at;
        int                inner_at;
        int                made;
        int                pick [2];
        logic [WEIGHT_W:0] sum;
        if (tree_built)
        begin
            set_size   = 0;
            tree_built = 1'b0;
        end
        if (set_size < MAX_WORDS)
        begin
            tree_weight[set_size] = WEIGHT_W'(cnt) & ((WEIGHT_W'(1) << COUNT_BITS) - 1);
            set_size++;
        end
        if (!fin)
            return;
        tree_built = 1'b1;
        n = set_size;
        if (n < 2)
            return;
        leaf_at  = n - 1;
        inner_at = n;
        for (int k = 0; k < n - 1; k++)
        begin
            made = n + k;
            for (int t = 0; t < 2; t++)
            begin
                if (leaf_at >= 0 &&
                    (inner_at >= made || tree_weight[leaf_at] < tree_weight[inner_at]))
                begin
                    pick[t] = leaf_at;
                    leaf_at--;
                end
                else
                begin
                    pick[t] = inner_at;
                    inner_at++;
                end
            end
            sum = tree_weight[pick[0]] + tree_weight[pick[1]];
            tree_weight[made]    = sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum[WEIGHT_W-1:0];
            tree_parent[pick[0]] = 11'(made);
            tree_parent[pick[1]] = 11'(made);
            tree_branch[pick[0]] = 1'b0;
            tree_branch[pick[1]] = 1'b1;
        end
    endfunction

    // Walk from the leaf up to the root, then queue the path root first.
    function automatic void trace_code_path(int word);
        int         n;
        int         root;
        int         node;
        int         len;
        int         path [MAX_CODE + 1];
        code_beat_t beat;
        n    = set_size;
        beat = '0;
        beat.last = 1'b1;
        if (!tree_built || n < 2 || word >= n)
        begin
            beat.error = ERR_NO_WORD;
            code_beats_due.push_back(beat);
            return;
        end
        root    = 2 * n - 2;
        node    = word;
        len     = 0;
        path[0] = word;
        while (node != root)
        begin
            if (len >= MAX_CODE)
            begin
                beat.error = ERR_TOO_LONG;
                code_beats_due.push_back(beat);
                return;
            end
            node = tree_parent[node];
            len++;
            path[len] = node;
        end
        for (int d = 0; d < len; d++)
        begin
            beat.code_bit   = tree_branch[path[len - 1 - d]];
            beat.node_index = NODE_W'(path[len - d] - n);
            beat.depth      = DEPTH_W'(d);
            beat.last       = (d == len - 1);
            beat.error      = ERR_OK;
            code_beats_due.push_back(beat);
        end
    endfunction

    // Offer one beat on the item channel, wait for it to be taken, then feed
    // it to the shadow model. Valid is only lowered when a gap follows, so it
    // stays high across back-to-back beats.
    task automatic issue_item(input logic beat_kind, input logic [COUNT_IN_W-1:0] cnt,
                              input logic fin, input logic [INDEX_W-1:0] idx,
                              input bit typed, input code_beat_t typed_beat);
        int gap;
        gap = draw_wait(0);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= beat_kind;
        item_ch.word_count <= cnt;
        item_ch.final_req  <= fin;
        item_ch.word_index <= idx;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_accepted++;
        if (beat_kind == KIND_LOAD)
            load_word_count(cnt, fin);
        else if (typed)
            code_beats_due.push_back(typed_beat);
        else
            trace_code_path(idx);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, capacity overrun, random sets.
    // ------------------------------------------------------------------------
    initial
    begin
        code_beat_t            want;
        logic [COUNT_IN_W-1:0] counts [$];
        logic [COUNT_IN_W-1:0] level;
        int                    random_start;
        int                    flavor;
        int                    shape;
        int                    n;
        int                    queries;
        int                    idx;

        // Every input is known from time zero; reset is held low at the start.
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.kind       = KIND_LOAD;
        item_ch.word_count = '0;
        item_ch.final_req  = 1'b0;
        item_ch.word_index = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed table. Typed rows always answer with a single beat at
        // depth zero with last set.
        foreach (directed_rows[r])
        begin
            want            = '0;
            want.code_bit   = directed_rows[r].t_bit;
            want.node_index = directed_rows[r].t_node;
            want.last       = 1'b1;
            want.error      = directed_rows[r].t_err;
            for (int k = 0; k < directed_rows[r].reps; k++)
                issue_item(directed_rows[r].kind, directed_rows[r].count,
                           directed_rows[r].final_req && (k == directed_rows[r].reps - 1),
                           directed_rows[r].index, directed_rows[r].typed, want);
        end

        // Overrun the capacity: the two loads past MAX_WORDS are dropped, and
        // the dropped one that carries the final marker still builds the tree.
        for (int i = 0; i < MAX_WORDS + 2; i++)
            issue_item(KIND_LOAD, COUNT_IN_W'(5_000_000 - i * 1000), i == MAX_WORDS + 1,
                       INDEX_W'($urandom()), 1'b0, no_beat);
        issue_item(KIND_QUERY, $urandom(), 1'b0, INDEX_W'(MAX_WORDS - 1), 1'b0, no_beat);
        issue_item(KIND_QUERY, $urandom(), 1'b1, 10'd0, 1'b0, no_beat);
        issue_item(KIND_QUERY, $urandom(), 1'b0, 10'd511, 1'b0, no_beat);
        repeat (4)
            issue_item(KIND_QUERY, $urandom(), 1'b0, INDEX_W'($urandom()), 1'b0, no_beat);

        // Random part. Most of it is whole sets followed by queries into them;
        // the rest is stray queries, sets cut off before their final load, and
        // one-word sets.
        random_phase = 1'b1;
        random_start = items_accepted;
        while (items_accepted - random_start < RANDOM_ITEMS)
        begin
            flavor = $urandom_range(0, 9);
            if (flavor <= 6)
            begin
                n     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(2, 12);
                shape = $urandom_range(0, 5);
                level = ($urandom_range(0, 1) == 0) ? '0 : $urandom() >> $urandom_range(0, 31);
                counts.delete();
                for (int i = 0; i < n; i++)
                    counts.push_back((shape == 4) ? level
                                                  : $urandom() >> $urandom_range(0, 31));
                // Shapes 0 to 3 are sorted as intended; shape 5 stays unsorted.
                if (shape < 4)
                    counts.rsort();
                for (int i = 0; i < n; i++)
                    issue_item(KIND_LOAD, counts[i], i == n - 1, INDEX_W'($urandom()),
                               1'b0, no_beat);
                queries = $urandom_range(1, 6);
                for (int q = 0; q < queries; q++)
                begin
                    idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, n - 1);
                    issue_item(KIND_QUERY, $urandom(), $urandom_range(0, 1), INDEX_W'(idx),
                               1'b0, no_beat);
                end
            end
            else if (flavor == 7)
            begin
                repeat (3)
                    issue_item(KIND_QUERY, $urandom(), $urandom_range(0, 1),
                               INDEX_W'($urandom()), 1'b0, no_beat);
            end
            else if (flavor == 8)
            begin
                // Loads without a final marker drop the old tree and build none.
                repeat ($urandom_range(1, 4))
                    issue_item(KIND_LOAD, $urandom(), 1'b0, INDEX_W'($urandom()),
                               1'b0, no_beat);
                repeat (2)
                    issue_item(KIND_QUERY, $urandom(), 1'b0, INDEX_W'($urandom_range(0, 4)),
                               1'b0, no_beat);
            end
            else
            begin
                issue_item(KIND_LOAD, $urandom(), 1'b1, INDEX_W'($urandom()), 1'b0, no_beat);
                issue_item(KIND_QUERY, $urandom(), 1'b0, 10'd0, 1'b0, no_beat);
            end
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;

        // Let every owed beat arrive, then watch a while longer for strays.
        while (code_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall at random, take one beat, compare it with the oldest
    // beat owed. Ready drops only at falling edges.
    // ------------------------------------------------------------------------
    initial
    begin
        code_beat_t want;
        int         stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(1);
            @(negedge clk);
            while (stall > 0 || long_hold)
            begin
                result_ch.ready <= 1'b0;
                stall--;
                @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            if (code_beats_due.size() == 0)
            begin
                $error("result beat arrived with no query waiting for it");
                mismatches++;
            end
            else
            begin
                want = code_beats_due.pop_front();
                if (result_ch.code_bit !== want.code_bit)
                begin
                    $error("code_bit: expected %0d, got %0d", want.code_bit, result_ch.code_bit);
                    mismatches++;
                end
                if (result_ch.node_index !== want.node_index)
                begin
                    $error("node_index: expected %0d, got %0d",
                           want.node_index, result_ch.node_index);
                    mismatches++;
                end
                if (result_ch.depth !== want.depth)
                begin
                    $error("depth: expected %0d, got %0d", want.depth, result_ch.depth);
                    mismatches++;
                end
                if (result_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result_ch.last);
                    mismatches++;
                end
                if (result_ch.error !== want.error)
                begin
                    $error("error: expected %0d, got %0d", want.error, result_ch.error);
                    mismatches++;
                end
            end
        end
    end

    // Once the random part is running and a query is in flight, the result
    // side holds off for a long stretch. The block keeps its output beat, stops
    // its emit steps and so backs up onto the item channel while items keep coming.
    initial
    begin
        wait (random_phase);
        while (code_beats_due.size() < 2)
            @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
